// ----- rtl/i2cmws_pkg.sv -----
package i2cmws_pkg;

    // ring buffer depth default
    localparam int DEFAULT_BUFFER_DEPTH = 256;

    // item kinds
    localparam logic [1:0] KIND_QUEUE  = 2'd0;
    localparam logic [1:0] KIND_ARM    = 2'd1;
    localparam logic [1:0] KIND_POLL   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // sequence phases
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT_BUS   = 3'd1;
    localparam logic [2:0] PH_WAIT_START = 3'd2;
    localparam logic [2:0] PH_WAIT_ADDR  = 3'd3;
    localparam logic [2:0] PH_SEND       = 3'd4;
    localparam logic [2:0] PH_WAIT_BYTE  = 3'd5;
    localparam logic [2:0] PH_WAIT_STOP  = 3'd6;

    // transfer status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // peripheral status patterns
    localparam logic [7:0]  S2_BUS_BUSY_BIT = 8'h02;
    localparam logic [15:0] S1_START_SENT   = 16'h0001;
    localparam logic [7:0]  S2_MASTER_BUSY  = 8'h03;
    localparam logic [15:0] S1_ADDR_SENT    = 16'h0082;
    localparam logic [15:0] S1_BYTE_DONE    = 16'h0084;
    localparam logic [7:0]  S2_MASTER_TX    = 8'h07;

    // configuration register indexes
    localparam int          CFG_IDX_W          = 1;
    localparam int          CFG_DATA_W         = 16;
    localparam logic [0:0]  REG_DEVICE_ADDRESS = 1'd0;
    localparam logic [0:0]  REG_STEP_TIMEOUT   = 1'd1;
    localparam logic [15:0] STEP_TIMEOUT_RESET = 16'd500;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  transfer_status;
        logic        byte_out_valid;
        logic [7:0]  byte_out;
        logic        start_request;
        logic        stop_request;
        logic [31:0] longest_wait_ms;
        logic        byte_accepted;
    } t_result;

endpackage

// ----- rtl/i2cmws_ram.sv -----
module i2cmws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/i2cmws_ctrl.sv -----
module i2cmws_ctrl #(
    parameter int BUFFER_DEPTH = i2cmws_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [1:0]                        i_kind,
    input  logic [7:0]                        i_data_byte,
    input  logic [31:0]                       i_now_ms,
    input  logic [15:0]                       i_status_one,
    input  logic [7:0]                        i_status_two,
    input  logic [6:0]                        i_device_address,
    input  logic [15:0]                       i_step_timeout_ms,
    output i2cmws_pkg::t_result               o_result,
    output logic [$clog2(BUFFER_DEPTH+1)-1:0] o_pending_bytes,
    output logic                              o_from_ram,
    output logic                              o_ram_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0]   o_ram_waddr,
    output logic [7:0]                        o_ram_wdata,
    output logic                              o_ram_re,
    output logic [$clog2(BUFFER_DEPTH)-1:0]   o_ram_raddr
);

    import i2cmws_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

    logic [2:0]       r_phase,    n_phase;
    logic [1:0]       r_status,   n_status;
    logic [31:0]      r_progress, n_progress;
    logic [31:0]      r_longest,  n_longest;
    logic [IDX_W-1:0] r_fill,     n_fill;
    logic [IDX_W-1:0] r_empty,    n_empty;
    logic [CNT_W-1:0] r_count,    n_count;

    logic [31:0] delta;
    logic        go;
    logic        we;
    logic        re;

    assign delta = i_now_ms - r_progress;

    always_comb begin
        n_phase    = r_phase;
        n_status   = r_status;
        n_progress = r_progress;
        n_longest  = r_longest;
        n_fill     = r_fill;
        n_empty    = r_empty;
        n_count    = r_count;
        we         = 1'b0;
        re         = 1'b0;
        go         = 1'b1;
        o_result   = '0;

        unique case (i_kind)
            KIND_QUEUE: begin
                if (r_count != CNT_FULL) begin
                    we      = 1'b1;
                    n_fill  = (r_fill == IDX_LAST) ? '0 : r_fill + 1'b1;
                    n_count = r_count + 1'b1;
                    o_result.byte_accepted = 1'b1;
                end
            end
            KIND_ARM: begin
                n_progress = i_now_ms;
                n_phase    = PH_WAIT_BUS;
                n_status   = ST_BUSY;
            end
            KIND_POLL: begin
                if (r_phase != PH_IDLE) begin
                    if (delta > {16'd0, i_step_timeout_ms}) begin
                        // abort: stop and drop everything queued
                        o_result.stop_request = 1'b1;
                        n_fill   = '0;
                        n_empty  = '0;
                        n_count  = '0;
                        n_phase  = PH_IDLE;
                        n_status = ST_TIMEOUT;
                        go       = 1'b0;
                    end else if (delta > r_longest) begin
                        n_longest = delta;
                    end
                end
                if (go) begin
                    unique case (r_phase)
                        PH_WAIT_BUS: begin
                            if ((i_status_two & S2_BUS_BUSY_BIT) == 8'd0) begin
                                o_result.start_request = 1'b1;
                                n_phase    = PH_WAIT_START;
                                n_progress = i_now_ms;
                            end
                        end
                        PH_WAIT_START: begin
                            if (i_status_one == S1_START_SENT &&
                                i_status_two == S2_MASTER_BUSY) begin
                                o_result.byte_out_valid = 1'b1;
                                o_result.byte_out       = {i_device_address, 1'b0};
                                n_phase    = PH_WAIT_ADDR;
                                n_progress = i_now_ms;
                            end
                        end
                        PH_WAIT_ADDR: begin
                            if (i_status_one == S1_ADDR_SENT &&
                                i_status_two == S2_MASTER_TX) begin
                                n_phase = PH_SEND;
                            end
                        end
                        PH_SEND: begin
                            if (r_count != '0) begin
                                // byte value arrives from the ring in the next cycle
                                re       = 1'b1;
                                n_count  = r_count - 1'b1;
                                n_empty  = (r_empty == IDX_LAST) ? '0 : r_empty + 1'b1;
                                o_result.byte_out_valid = 1'b1;
                                n_progress = i_now_ms;
                                n_phase    = PH_WAIT_BYTE;
                            end else begin
                                o_result.stop_request = 1'b1;
                                n_status = ST_DONE;
                                n_phase  = PH_IDLE;
                            end
                        end
                        PH_WAIT_BYTE: begin
                            if (i_status_one == S1_BYTE_DONE &&
                                i_status_two == S2_MASTER_TX) begin
                                n_phase = PH_SEND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        o_result.phase           = n_phase;
        o_result.transfer_status = n_status;
        o_result.longest_wait_ms = n_longest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_status   <= ST_DONE;
            r_progress <= '0;
            r_longest  <= '0;
            r_fill     <= '0;
            r_empty    <= '0;
            r_count    <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_status   <= n_status;
            r_progress <= n_progress;
            r_longest  <= n_longest;
            r_fill     <= n_fill;
            r_empty    <= n_empty;
            r_count    <= n_count;
        end
    end

    assign o_pending_bytes = n_count;
    assign o_from_ram      = re;
    assign o_ram_we        = i_accept & we;
    assign o_ram_waddr     = r_fill;
    assign o_ram_wdata     = i_data_byte;
    assign o_ram_re        = i_accept & re;
    assign o_ram_raddr     = r_empty;

endmodule

// ----- rtl/i2c_master_write_sequencer.sv -----
// result: registered when the transaction is accepted; a send step that reads a data
//   byte out of the ring memory waits for the ring read before the result is valid
// throughput: one item per cycle unless stalled downstream or a ring read is outstanding
// reset: synchronous, active low; clears phase, status, pointers, counters and the
//   longest wait, returns the config registers to their reset values (address zero,
//   timeout 500 ms); ring memory contents are not cleared
module i2c_master_write_sequencer #(
    parameter int BUFFER_DEPTH = i2cmws_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i2cmws_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2cmws_pkg::CFG_DATA_W-1:0]   i_cfg_data,

    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_kind,
    input  logic [7:0]                          i_data_byte,
    input  logic [31:0]                         i_now_ms,
    input  logic [15:0]                         i_status_one,
    input  logic [7:0]                          i_status_two,

    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_phase,
    output logic [1:0]                          o_transfer_status,
    output logic                                o_byte_out_valid,
    output logic [7:0]                          o_byte_out,
    output logic                                o_start_request,
    output logic                                o_stop_request,
    output logic [$clog2(BUFFER_DEPTH+1)-1:0]   o_pending_bytes,
    output logic [31:0]                         o_longest_wait_ms,
    output logic                                o_byte_accepted
);

    import i2cmws_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    // configuration registers
    logic [6:0]  r_device_address;
    logic [15:0] r_step_timeout_ms;

    // handshake and output register
    logic             r_out_valid;
    logic             r_rd_pend;      // result waits for the ring read data
    t_result          r_result;
    logic [CNT_W-1:0] r_pending;

    logic             in_accept;
    logic             cfg_write;

    // controller outputs
    t_result          ctl_result;
    logic [CNT_W-1:0] ctl_pending;
    logic             ctl_from_ram;

    // ring memory port signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    // one item in flight: hold off while the ring read is outstanding or the
    // finished result is still stalled downstream
    assign o_in_stall  = r_rd_pend | (r_out_valid & i_out_stall);
    assign in_accept   = i_in_valid & ~o_in_stall;

    // config writes are always taken; software is to write only while idle, not enforced here
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;

    // phase machine, ring pointers, counters and timing registers
    i2cmws_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_kind            (i_kind),
        .i_data_byte       (i_data_byte),
        .i_now_ms          (i_now_ms),
        .i_status_one      (i_status_one),
        .i_status_two      (i_status_two),
        .i_device_address  (r_device_address),
        .i_step_timeout_ms (r_step_timeout_ms),
        .o_result          (ctl_result),
        .o_pending_bytes   (ctl_pending),
        .o_from_ram        (ctl_from_ram),
        .o_ram_we          (ram_we),
        .o_ram_waddr       (ram_waddr),
        .o_ram_wdata       (ram_wdata),
        .o_ram_re          (ram_re),
        .o_ram_raddr       (ram_raddr)
    );

    // byte ring storage, write on queue, read on send
    i2cmws_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control flops and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_rd_pend         <= 1'b0;
            r_device_address  <= '0;
            r_step_timeout_ms <= STEP_TIMEOUT_RESET;
        end else begin
            if (in_accept) begin
                // a ring read holds the result back until the read data has returned
                r_rd_pend   <= ctl_from_ram;
                r_out_valid <= ~ctl_from_ram;
            end else if (r_rd_pend) begin
                r_rd_pend   <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_write) begin
                unique case (i_cfg_index)
                    REG_DEVICE_ADDRESS: r_device_address  <= i_cfg_data[6:0];
                    REG_STEP_TIMEOUT:   r_step_timeout_ms <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // result payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result  <= ctl_result;
            r_pending <= ctl_pending;
        end else if (r_rd_pend) begin
            // fill in the data byte now that the ring read has returned
            r_result.byte_out <= ram_rdata;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_phase           = r_result.phase;
    assign o_transfer_status = r_result.transfer_status;
    assign o_byte_out_valid  = r_result.byte_out_valid;
    assign o_byte_out        = r_result.byte_out;
    assign o_start_request   = r_result.start_request;
    assign o_stop_request    = r_result.stop_request;
    assign o_pending_bytes   = r_pending;
    assign o_longest_wait_ms = r_result.longest_wait_ms;
    assign o_byte_accepted   = r_result.byte_accepted;

endmodule
